// File: rtl/core/wctt_pkg.sv
//------------------------------------------------------------------------------
// wctt_pkg
// Types, codes and constants shared by the weighted two-way count table.
//------------------------------------------------------------------------------
`default_nettype none

package wctt_pkg;

  localparam int CELL_W    = 31;
  localparam int LEVEL_W   = 5;
  localparam int WEIGHT_W  = 16;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 2;

  localparam int X_SIZE_DEF = 32;
  localparam int Y_SIZE_DEF = 32;

  localparam logic [CELL_W-1:0]    CELL_MAX      = {CELL_W{1'b1}};
  localparam logic [CFG_W-1:0]     LEVELS_RESET  = 6'd32;
  localparam logic [CFG_IDX_W-1:0] CFG_X_LEVELS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LEVELS  = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACCUM = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load_item;
    logic mem_read;
    logic clr_write;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/weighted_two_way_count_table_unit.sv
//------------------------------------------------------------------------------
// weighted_two_way_count_table_unit
// Two-way count table: clears, accumulates weights into and reads cells
// of an X_SIZE by Y_SIZE table of saturating 31-bit counts.
//
//   channel | direction | words
//   s_*     | in        | command: opcode, x level, y level, weight
//   m_*     | out       | result: cell count, range error, saturated
//   cfg_*   | in        | level register writes, no read-back
//
// Accumulate and read go through three steps: accept, memory read, update.
// A clear walks the table one cell a cycle.
// After reset the same pass over all X_SIZE * Y_SIZE cells runs with s_tready low.
// The result register lets the next word be accepted while a result waits;
// that word's update holds until the result is taken.
//------------------------------------------------------------------------------
`default_nettype none

module weighted_two_way_count_table_unit #(
  parameter int X_SIZE = wctt_pkg::X_SIZE_DEF,
  parameter int Y_SIZE = wctt_pkg::Y_SIZE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // x_level, y_level, weight
  input  wire logic [wctt_pkg::S_TDATA_W-1:0] s_tdata,
  // opcode
  input  wire logic [wctt_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // cell_count
  output logic [wctt_pkg::M_TDATA_W-1:0]      m_tdata,
  // range_error, saturated
  output logic [wctt_pkg::M_TUSER_W-1:0]      m_tuser,
  input  wire logic                           cfg_we,
  input  wire logic [wctt_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [wctt_pkg::CFG_W-1:0]     cfg_wdata
);
  import wctt_pkg::*;

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic [LEVEL_W-1:0]  in_x_level;
  logic [LEVEL_W-1:0]  in_y_level;
  logic [WEIGHT_W-1:0] in_weight;
  logic [CELL_W-1:0]   cell_count;
  logic                range_error;
  logic                saturated;

  assign in_x_level = s_tdata[LEVEL_W-1:0];
  assign in_y_level = s_tdata[2*LEVEL_W-1:LEVEL_W];
  assign in_weight  = s_tdata[2*LEVEL_W+WEIGHT_W-1:2*LEVEL_W];

  assign m_tdata = M_TDATA_W'(cell_count);
  assign m_tuser = {saturated, range_error};

  wctt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .in_opcode (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  wctt_dp #(
    .X_SIZE (X_SIZE),
    .Y_SIZE (Y_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_opcode   (s_tuser),
    .in_x_level  (in_x_level),
    .in_y_level  (in_y_level),
    .in_weight   (in_weight),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .cell_count  (cell_count),
    .range_error (range_error),
    .saturated   (saturated)
  );

endmodule

`default_nettype wire

// File: rtl/core/wctt_ctrl.sv
//------------------------------------------------------------------------------
// wctt_ctrl
// Controller: sequences the clearing pass, the memory read and the update,
// and owns the output word valid flag.
//------------------------------------------------------------------------------
`default_nettype none

module wctt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [1:0]         in_opcode,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output wctt_pkg::dp_cmd_t       cmd,
  input  wire wctt_pkg::dp_stat_t stat
);
  import wctt_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT_CLR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_INIT_CLR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next = (in_opcode == OP_CLEAR) ? ST_CLEAR : ST_READ;
        end
      end
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_finish_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken word");

  a_clear_end_in_pass: assert property (@(posedge clk) disable iff (rst)
    stat.clr_last |-> (state == ST_INIT_CLR || state == ST_CLEAR))
    else $error("clear counter at last cell outside a clearing pass");

  a_accept_leads_to_work: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> (state == ST_CLEAR || state == ST_READ))
    else $error("accepted word did not start work");

endmodule

`default_nettype wire

// File: rtl/core/wctt_dp.sv
//------------------------------------------------------------------------------
// wctt_dp
// Datapath: level registers, item registers, count memory with registered
// read, saturating adder, clear counter and the result register.
//------------------------------------------------------------------------------
`default_nettype none

module wctt_dp #(
  parameter int X_SIZE = wctt_pkg::X_SIZE_DEF,
  parameter int Y_SIZE = wctt_pkg::Y_SIZE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire wctt_pkg::dp_cmd_t              cmd,
  output wctt_pkg::dp_stat_t                  stat,
  input  wire logic [1:0]                     in_opcode,
  input  wire logic [wctt_pkg::LEVEL_W-1:0]   in_x_level,
  input  wire logic [wctt_pkg::LEVEL_W-1:0]   in_y_level,
  input  wire logic [wctt_pkg::WEIGHT_W-1:0]  in_weight,
  input  wire logic                           cfg_we,
  input  wire logic [wctt_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [wctt_pkg::CFG_W-1:0]     cfg_wdata,
  output logic [wctt_pkg::CELL_W-1:0]         cell_count,
  output logic                                range_error,
  output logic                                saturated
);
  import wctt_pkg::*;

  localparam int DEPTH = X_SIZE * Y_SIZE;
  localparam int AW    = $clog2(DEPTH);

  logic [CFG_W-1:0]    x_levels;
  logic [CFG_W-1:0]    y_levels;
  logic [1:0]          item_op;
  logic [WEIGHT_W-1:0] item_weight;
  logic [AW-1:0]       item_addr;
  logic                item_range_ok;
  logic [AW-1:0]       clr_cnt;
  logic [CELL_W-1:0]   rd_data;
  logic [CELL_W-1:0]   mem [DEPTH];

  logic                in_range_ok;
  logic [31:0]         addr_full;
  logic [CELL_W:0]     sum;
  logic                sum_sat;
  logic [CELL_W-1:0]   acc_val;
  logic                mem_we;
  logic [AW-1:0]       waddr;
  logic [CELL_W-1:0]   wdata;
  logic [CELL_W-1:0]   res_cell;
  logic                res_rerr;
  logic                res_sat;

  assign in_range_ok = ({1'b0, in_x_level} < x_levels) &&
                       ({1'b0, in_y_level} < y_levels) &&
                       (32'(in_x_level) < 32'(X_SIZE)) &&
                       (32'(in_y_level) < 32'(Y_SIZE));
  assign addr_full   = 32'(in_x_level) + 32'(in_y_level) * 32'(X_SIZE);

  assign stat.clr_last = (clr_cnt == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      x_levels <= LEVELS_RESET;
      y_levels <= LEVELS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_X_LEVELS: x_levels <= cfg_wdata;
        CFG_Y_LEVELS: y_levels <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_write) begin
      clr_cnt <= stat.clr_last ? '0 : clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op       <= in_opcode;
      item_weight   <= in_weight;
      item_addr     <= addr_full[AW-1:0];
      item_range_ok <= in_range_ok;
    end
  end

  assign sum     = {1'b0, rd_data} + (CELL_W + 1)'(item_weight);
  assign sum_sat = (sum >= {1'b0, CELL_MAX});
  assign acc_val = sum_sat ? CELL_MAX : sum[CELL_W-1:0];

  assign mem_we = cmd.clr_write ||
                  (cmd.finish && item_op == OP_ACCUM && item_range_ok);
  assign waddr  = cmd.clr_write ? clr_cnt : item_addr;
  assign wdata  = cmd.clr_write ? '0 : acc_val;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.mem_read) begin
      rd_data <= mem[item_addr];
    end
  end

  always_comb begin
    res_cell = '0;
    res_rerr = 1'b0;
    res_sat  = 1'b0;
    case (item_op)
      OP_ACCUM: begin
        if (item_range_ok) begin
          res_cell = acc_val;
          res_sat  = sum_sat;
        end else begin
          res_rerr = 1'b1;
        end
      end
      OP_READ: begin
        if (item_range_ok) begin
          res_cell = rd_data;
        end else begin
          res_rerr = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      cell_count  <= res_cell;
      range_error <= res_rerr;
      saturated   <= res_sat;
    end
  end

  a_sat_means_max: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && res_sat |=> cell_count == CELL_MAX)
    else $error("saturated result without maximum count");

  a_rerr_zero_cell: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && res_rerr |=> cell_count == '0 && !saturated)
    else $error("range error result carries a count");

  a_no_clear_and_update: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_write |-> !cmd.finish && !cmd.mem_read)
    else $error("clearing pass overlaps item work");

endmodule

`default_nettype wire
